@@ src/srv_pkg.sv @@
// Shared constants, register indexes and gain table of the reverb block.
package srv_pkg;

  localparam int NUM_COMB      = 4;
  localparam int NUM_ALLP      = 3;
  localparam int IDX_BITS      = 2;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int WET_BITS      = 16;
  localparam int COMB_LEN_BITS = 13;
  localparam int ALLP_LEN_BITS = 10;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_WET_MIX      = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_COMB0_LENGTH = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_COMB1_LENGTH = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_COMB2_LENGTH = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_COMB3_LENGTH = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_ALLP0_LENGTH = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_ALLP1_LENGTH = 3'd6;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_ALLP2_LENGTH = 3'd7;

  localparam logic [WET_BITS-1:0]      WET_RESET        = 16'd16384;
  localparam logic [COMB_LEN_BITS-1:0] COMB0_LEN_RESET  = 13'd3460;
  localparam logic [COMB_LEN_BITS-1:0] COMB1_LEN_RESET  = 13'd2988;
  localparam logic [COMB_LEN_BITS-1:0] COMB2_LEN_RESET  = 13'd3882;
  localparam logic [COMB_LEN_BITS-1:0] COMB3_LEN_RESET  = 13'd4093;
  localparam logic [ALLP_LEN_BITS-1:0] ALLP0_LEN_RESET  = 10'd480;
  localparam logic [ALLP_LEN_BITS-1:0] ALLP1_LEN_RESET  = 10'd161;
  localparam logic [ALLP_LEN_BITS-1:0] ALLP2_LEN_RESET  = 10'd46;

  // Unsigned Q1.15 gains and mix weights; 0x8000 is unity
  localparam int                  FRAC_BITS  = 15;
  localparam int                  ROUND_HALF = 16384;
  localparam int                  COEF_BITS  = 16;
  localparam logic [COEF_BITS-1:0] UNITY        = 16'h8000;
  localparam logic [COEF_BITS-1:0] GAIN_ALLPASS = 16'd22938;

  function automatic logic [COEF_BITS-1:0] comb_gain(input logic [IDX_BITS-1:0] k);
    case (k)
      2'd0:    return 16'd26378;
      2'd1:    return 16'd27099;
      2'd2:    return 16'd25657;
      2'd3:    return 16'd25035;
      default: return '0;
    endcase
  endfunction

endpackage

@@ src/schroeder_reverb.sv @@
// Top level of the Schroeder reverb: four comb filters, three allpass sections, dry/wet mix.
//
// One stereo word enters on the s_ side and one mixed word leaves on the m_ side. The
// left sample drives four feedback comb filters whose outputs are averaged and sent
// through three allpass sections in series; both channels then blend their dry sample
// with that reverb signal by wet_mix. All seven delay lines live in two memories (the
// four comb lines share one, the three allpass lines share the other), and a single
// 17-bit-coefficient multiplier serves every gain and mix product. Each word is worked
// through one read-multiply-write step at a time: read, multiply and write for each comb,
// then averaging, then read, feedback term, multiply and write for each allpass, then
// the wet, dry-left and dry-right mix products; a new word is accepted only once the
// block is idle again, set by that one shared multiplier and the one memory port per
// line group. The result sits in an output register, so the next word is accepted while
// the previous one still waits on m_tready. After reset a clearing pass zeroes the
// memories, during which s_tready stays low; configuration writes are taken at any time
// but belong to idle periods.
module schroeder_reverb #(
  parameter int COMB_DEPTH    = 4096,
  parameter int ALLPASS_DEPTH = 512,
  parameter int SAMPLE_BITS   = 16,
  parameter int LINE_BITS     = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_we,
  input  logic [srv_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [srv_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,   // left_in, right_in
  input  logic                               s_tlast,   // frame_last
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,   // left_out, right_out
  output logic                               m_tlast    // frame_last_out
);

  localparam int DW   = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int CPW  = $clog2(COMB_DEPTH);
  localparam int APW  = $clog2(ALLPASS_DEPTH);
  localparam int CAW  = CPW + srv_pkg::IDX_BITS;
  localparam int AAW  = APW + srv_pkg::IDX_BITS;
  localparam int CLW  = (CAW > AAW) ? CAW : AAW;
  localparam int MAXW = (LINE_BITS > SAMPLE_BITS) ? LINE_BITS : SAMPLE_BITS;
  localparam int AW   = MAXW + 2;                       // multiplier data operand
  localparam int BW   = srv_pkg::COEF_BITS + 1;         // multiplier coefficient operand
  localparam int PW   = AW + BW;                        // product
  localparam int SW   = MAXW + 3;                       // rounded sums before saturation
  localparam int ACW  = LINE_BITS + 2;                  // comb accumulator
  localparam int CEW  = ((srv_pkg::COMB_LEN_BITS > CPW + 1) ?
                         srv_pkg::COMB_LEN_BITS : CPW + 1) + 1;
  localparam int AEW  = ((srv_pkg::ALLP_LEN_BITS > APW + 1) ?
                         srv_pkg::ALLP_LEN_BITS : APW + 1) + 1;

  localparam logic signed [PW-1:0]  RND_P     = PW'(srv_pkg::ROUND_HALF);
  localparam logic signed [ACW-1:0] AVG_RND   = ACW'(2);
  localparam logic signed [SW-1:0]  LINE_MAX  = SW'((64'sd1 <<< (LINE_BITS-1)) - 64'sd1);
  localparam logic signed [SW-1:0]  LINE_MIN  = SW'(-(64'sd1 <<< (LINE_BITS-1)));
  localparam logic signed [SW-1:0]  SAMP_MAX  = SW'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
  localparam logic signed [SW-1:0]  SAMP_MIN  = SW'(-(64'sd1 <<< (SAMPLE_BITS-1)));

  // sequencer codes
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CRD   = 4'd2;   // read comb line
  localparam logic [3:0] ST_CMUL  = 4'd3;   // line * comb gain
  localparam logic [3:0] ST_CWR   = 4'd4;   // add input, saturate, write back
  localparam logic [3:0] ST_AVG   = 4'd5;   // average of the four combs
  localparam logic [3:0] ST_ARD   = 4'd6;   // read allpass line, v * gain
  localparam logic [3:0] ST_AF    = 4'd7;   // feedback term f
  localparam logic [3:0] ST_AMUL  = 4'd8;   // f * gain
  localparam logic [3:0] ST_AWR   = 4'd9;   // add v, saturate, write back
  localparam logic [3:0] ST_M0    = 4'd10;  // wet * rev
  localparam logic [3:0] ST_M1    = 4'd11;  // dry * left
  localparam logic [3:0] ST_M2    = 4'd12;  // left result, dry * right
  localparam logic [3:0] ST_OUT   = 4'd13;  // right result, load output register

  logic [3:0] state;
  logic [srv_pkg::IDX_BITS-1:0] idx;
  logic [CLW-1:0] clr_cnt;

  // configuration registers
  logic [srv_pkg::WET_BITS-1:0]      wet;
  logic [srv_pkg::COMB_LEN_BITS-1:0] comb_len [srv_pkg::NUM_COMB];
  logic [srv_pkg::ALLP_LEN_BITS-1:0] allp_len [srv_pkg::NUM_ALLP];

  // line positions
  logic [CPW-1:0] cpos [srv_pkg::NUM_COMB];
  logic [APW-1:0] apos [srv_pkg::NUM_ALLP];

  // datapath registers
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] r;
  logic                          last_q;
  logic signed [ACW-1:0]         acc;
  logic signed [LINE_BITS-1:0]   v;
  logic signed [AW-1:0]          f;
  logic signed [PW-1:0]          prod;
  logic signed [PW-1:0]          wv;
  logic signed [SAMPLE_BITS-1:0] lo;

  // memories
  logic                 comb_we, comb_re;
  logic [CAW-1:0]       comb_waddr, comb_raddr;
  logic [LINE_BITS-1:0] comb_wdata, comb_rdata;
  logic                 allp_we, allp_re;
  logic [AAW-1:0]       allp_waddr, allp_raddr;
  logic [LINE_BITS-1:0] allp_wdata, allp_rdata;

  // combinational
  logic signed [AW-1:0]          mul_a;
  logic signed [BW-1:0]          mul_b;
  logic                          mul_en;
  logic signed [PW-1:0]          prod_rnd;
  logic signed [SW-1:0]          rnd_s;
  logic signed [LINE_BITS-1:0]   c_w, a_w;
  logic signed [ACW-1:0]         avg_sum;
  logic signed [PW-1:0]          mix_sum, mix_rnd;
  logic signed [SAMPLE_BITS-1:0] mix_out;
  logic [srv_pkg::COEF_BITS-1:0] wet_eff, dry;
  logic [CEW-1:0]                c_len, c_eff, c_step;
  logic [AEW-1:0]                a_len, a_eff, a_step;
  logic [CPW-1:0]                c_pos_next;
  logic [APW-1:0]                a_pos_next;
  logic                          clearing, out_load, in_accept;

  function automatic logic signed [LINE_BITS-1:0] sat_line(input logic signed [SW-1:0] a);
    if (a > LINE_MAX) begin
      return LINE_MAX[LINE_BITS-1:0];
    end else if (a < LINE_MIN) begin
      return LINE_MIN[LINE_BITS-1:0];
    end
    return a[LINE_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_samp(input logic signed [SW-1:0] a);
    if (a > SAMP_MAX) begin
      return SAMP_MAX[SAMPLE_BITS-1:0];
    end else if (a < SAMP_MIN) begin
      return SAMP_MIN[SAMPLE_BITS-1:0];
    end
    return a[SAMPLE_BITS-1:0];
  endfunction

  assign clearing  = (state == ST_CLEAR);
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_load  = (state == ST_OUT) && (!m_tvalid || m_tready);

  // Wet weight clamps at unity; dry is its complement.
  assign wet_eff = (wet > srv_pkg::UNITY) ? srv_pkg::UNITY : wet;
  assign dry     = srv_pkg::UNITY - wet_eff;

  // Effective lengths and position advance for the line under work. A zero length acts
  // as one, a length beyond the depth acts as the depth, and a position left past a
  // shrunk length is used once more before it wraps.
  always_comb begin
    c_len = CEW'(comb_len[idx]);
    if (c_len == '0) begin
      c_eff = CEW'(1);
    end else if (c_len > CEW'(COMB_DEPTH)) begin
      c_eff = CEW'(COMB_DEPTH);
    end else begin
      c_eff = c_len;
    end
    c_step     = CEW'(cpos[idx]) + CEW'(1);
    c_pos_next = (c_step >= c_eff) ? '0 : c_step[CPW-1:0];

    a_len = AEW'(allp_len[idx]);
    if (a_len == '0) begin
      a_eff = AEW'(1);
    end else if (a_len > AEW'(ALLPASS_DEPTH)) begin
      a_eff = AEW'(ALLPASS_DEPTH);
    end else begin
      a_eff = a_len;
    end
    a_step     = AEW'(apos[idx]) + AEW'(1);
    a_pos_next = (a_step >= a_eff) ? '0 : a_step[APW-1:0];
  end

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    case (state)
      ST_CMUL: begin
        mul_a  = AW'($signed(comb_rdata));
        mul_b  = $signed(BW'(srv_pkg::comb_gain(idx)));
        mul_en = 1'b1;
      end
      ST_ARD: begin
        mul_a  = AW'(v);
        mul_b  = $signed(BW'(srv_pkg::GAIN_ALLPASS));
        mul_en = 1'b1;
      end
      ST_AMUL: begin
        mul_a  = f;
        mul_b  = $signed(BW'(srv_pkg::GAIN_ALLPASS));
        mul_en = 1'b1;
      end
      ST_M0: begin
        mul_a  = AW'(v);
        mul_b  = $signed(BW'(wet_eff));
        mul_en = 1'b1;
      end
      ST_M1: begin
        mul_a  = AW'(x);
        mul_b  = $signed(BW'(dry));
        mul_en = 1'b1;
      end
      ST_M2: begin
        mul_a  = AW'(r);
        mul_b  = $signed(BW'(dry));
        mul_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Round half up, floor by 2^15; the same net serves comb and allpass terms, and the mix sum is rounded alike.
  always_comb begin
    prod_rnd = (prod + RND_P) >>> srv_pkg::FRAC_BITS;
    rnd_s    = $signed(prod_rnd[SW-1:0]);
    c_w      = sat_line(rnd_s + SW'(x));
    a_w      = sat_line(rnd_s + SW'(v));
    avg_sum  = (acc + AVG_RND) >>> 2;
    mix_sum  = prod + wv;
    mix_rnd  = (mix_sum + RND_P) >>> srv_pkg::FRAC_BITS;
    mix_out  = sat_samp($signed(mix_rnd[SW-1:0]));
  end

  // Memory ports: the clearing pass owns the write side until it finishes.
  assign comb_raddr = {idx, cpos[idx]};
  assign allp_raddr = {idx, apos[idx]};
  assign comb_re    = (state == ST_CRD);
  assign allp_re    = (state == ST_ARD);
  assign comb_we    = clearing ? ((clr_cnt >> CAW) == '0) : (state == ST_CWR);
  assign allp_we    = clearing ? ((clr_cnt >> AAW) == '0) : (state == ST_AWR);
  assign comb_waddr = clearing ? clr_cnt[CAW-1:0] : comb_raddr;
  assign allp_waddr = clearing ? clr_cnt[AAW-1:0] : allp_raddr;
  assign comb_wdata = clearing ? '0 : c_w;
  assign allp_wdata = clearing ? '0 : a_w;

  srv_ram #(.WIDTH(LINE_BITS), .ADDR_BITS(CAW)) u_comb_ram (
    .clk   (clk),
    .we    (comb_we),
    .waddr (comb_waddr),
    .wdata (comb_wdata),
    .re    (comb_re),
    .raddr (comb_raddr),
    .rdata (comb_rdata)
  );

  srv_ram #(.WIDTH(LINE_BITS), .ADDR_BITS(AAW)) u_allp_ram (
    .clk   (clk),
    .we    (allp_we),
    .waddr (allp_waddr),
    .wdata (allp_wdata),
    .re    (allp_re),
    .raddr (allp_raddr),
    .rdata (allp_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      wet         <= srv_pkg::WET_RESET;
      comb_len[0] <= srv_pkg::COMB0_LEN_RESET;
      comb_len[1] <= srv_pkg::COMB1_LEN_RESET;
      comb_len[2] <= srv_pkg::COMB2_LEN_RESET;
      comb_len[3] <= srv_pkg::COMB3_LEN_RESET;
      allp_len[0] <= srv_pkg::ALLP0_LEN_RESET;
      allp_len[1] <= srv_pkg::ALLP1_LEN_RESET;
      allp_len[2] <= srv_pkg::ALLP2_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        srv_pkg::CFG_WET_MIX:      wet         <= cfg_data[srv_pkg::WET_BITS-1:0];
        srv_pkg::CFG_COMB0_LENGTH: comb_len[0] <= cfg_data[srv_pkg::COMB_LEN_BITS-1:0];
        srv_pkg::CFG_COMB1_LENGTH: comb_len[1] <= cfg_data[srv_pkg::COMB_LEN_BITS-1:0];
        srv_pkg::CFG_COMB2_LENGTH: comb_len[2] <= cfg_data[srv_pkg::COMB_LEN_BITS-1:0];
        srv_pkg::CFG_COMB3_LENGTH: comb_len[3] <= cfg_data[srv_pkg::COMB_LEN_BITS-1:0];
        srv_pkg::CFG_ALLP0_LENGTH: allp_len[0] <= cfg_data[srv_pkg::ALLP_LEN_BITS-1:0];
        srv_pkg::CFG_ALLP1_LENGTH: allp_len[1] <= cfg_data[srv_pkg::ALLP_LEN_BITS-1:0];
        srv_pkg::CFG_ALLP2_LENGTH: allp_len[2] <= cfg_data[srv_pkg::ALLP_LEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      idx     <= '0;
      clr_cnt <= '0;
      for (int i = 0; i < srv_pkg::NUM_COMB; i++) begin
        cpos[i] <= '0;
      end
      for (int i = 0; i < srv_pkg::NUM_ALLP; i++) begin
        apos[i] <= '0;
      end
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + CLW'(1);
          if (&clr_cnt) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            idx   <= '0;
            state <= ST_CRD;
          end
        end
        ST_CRD:  state <= ST_CMUL;
        ST_CMUL: state <= ST_CWR;
        ST_CWR: begin
          cpos[idx] <= c_pos_next;
          if (idx == srv_pkg::IDX_BITS'(srv_pkg::NUM_COMB - 1)) begin
            idx   <= '0;
            state <= ST_AVG;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_CRD;
          end
        end
        ST_AVG:  state <= ST_ARD;
        ST_ARD:  state <= ST_AF;
        ST_AF:   state <= ST_AMUL;
        ST_AMUL: state <= ST_AWR;
        ST_AWR: begin
          apos[idx] <= a_pos_next;
          if (idx == srv_pkg::IDX_BITS'(srv_pkg::NUM_ALLP - 1)) begin
            idx   <= '0;
            state <= ST_M0;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_ARD;
          end
        end
        ST_M0: state <= ST_M1;
        ST_M1: state <= ST_M2;
        ST_M2: state <= ST_OUT;
        ST_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      x      <= $signed(s_tdata[SAMPLE_BITS-1:0]);
      r      <= $signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
      last_q <= s_tlast;
      acc    <= '0;
    end
    if (state == ST_CWR) begin
      acc <= acc + ACW'(c_w);
    end
    if (state == ST_AVG) begin
      v <= avg_sum[LINE_BITS-1:0];
    end
    if (state == ST_AF) begin
      f <= AW'($signed(allp_rdata)) - $signed(rnd_s[AW-1:0]);
    end
    if (state == ST_AWR) begin
      v <= a_w;
    end
    if (state == ST_M1) begin
      wv <= prod;
    end
    if (state == ST_M2) begin
      lo <= mix_out;
    end
  end

  // Output register: parts the sequencer from the downstream stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= DW'({mix_out, lo});
      m_tlast <= last_q;
    end
  end

  // Every word runs the full fixed schedule to the output step.
  a_schedule: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> ##29 (state == ST_OUT))
    else $error("sequencer did not reach output step on schedule");

  // Comb write-back lands on the entry read in the comb read step.
  a_comb_rmw: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CWR) |-> (comb_waddr == $past(comb_raddr, 2)))
    else $error("comb write-back address differs from read address");

  // Allpass steps never address the unused fourth line group.
  a_allp_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ARD || state == ST_AF || state == ST_AMUL || state == ST_AWR)
      |-> (idx != srv_pkg::IDX_BITS'(srv_pkg::NUM_ALLP)))
    else $error("allpass index out of range");

  // A new result appears only from the output step.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_OUT))
    else $error("output loaded outside the output step");

endmodule

@@ src/srv_ram.sv @@
// Simple dual-port delay-line memory, one write and one registered read per cycle.
module srv_ram #(
  parameter int WIDTH     = 20,
  parameter int ADDR_BITS = 14
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [1 << ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sim/tb.sv @@
// Testbench for schroeder_reverb: stream driver, stream sink and a frame-accurate scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SMP_BITS      = 16;
  localparam int LINE_W        = 20;
  localparam int COMB_WORDS    = 4096;
  localparam int ALLP_WORDS    = 512;
  localparam int FULL_WET      = 32768;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_FRAMES = 230;

  // feedback gains of the four comb filters and the allpass gain, Q0.15
  localparam longint COMB_GAINS [srv_pkg::NUM_COMB] = '{26378, 27099, 25657, 25035};
  localparam longint ALLP_GAIN                      = 22938;

  // register indexes in write order
  localparam logic [srv_pkg::CFG_ADDR_BITS-1:0] REG_ORDER [8] = '{
    srv_pkg::CFG_WET_MIX, srv_pkg::CFG_COMB0_LENGTH, srv_pkg::CFG_COMB1_LENGTH,
    srv_pkg::CFG_COMB2_LENGTH, srv_pkg::CFG_COMB3_LENGTH, srv_pkg::CFG_ALLP0_LENGTH,
    srv_pkg::CFG_ALLP1_LENGTH, srv_pkg::CFG_ALLP2_LENGTH};

  typedef struct packed {
    logic [SMP_BITS-1:0] left;
    logic [SMP_BITS-1:0] right;
    logic                last;
  } stereo_word_t;

  // Tracks the reverb state and holds the mixed words still owed by the block.
  class reverb_scoreboard;
    logic [srv_pkg::WET_BITS-1:0]      wet_reg;
    logic [srv_pkg::COMB_LEN_BITS-1:0] comb_len [srv_pkg::NUM_COMB];
    logic [srv_pkg::ALLP_LEN_BITS-1:0] allp_len [srv_pkg::NUM_ALLP];
    int                                comb_mem [srv_pkg::NUM_COMB][COMB_WORDS];
    int                                allp_mem [srv_pkg::NUM_ALLP][ALLP_WORDS];
    int                                comb_pos [srv_pkg::NUM_COMB];
    int                                allp_pos [srv_pkg::NUM_ALLP];
    stereo_word_t                      owed_q [$];
    int                                errors;
    int                                words_checked;

    function new();
      wet_reg     = srv_pkg::WET_RESET;
      comb_len[0] = srv_pkg::COMB0_LEN_RESET;
      comb_len[1] = srv_pkg::COMB1_LEN_RESET;
      comb_len[2] = srv_pkg::COMB2_LEN_RESET;
      comb_len[3] = srv_pkg::COMB3_LEN_RESET;
      allp_len[0] = srv_pkg::ALLP0_LEN_RESET;
      allp_len[1] = srv_pkg::ALLP1_LEN_RESET;
      allp_len[2] = srv_pkg::ALLP2_LEN_RESET;
      foreach (comb_mem[k, i]) comb_mem[k][i] = 0;
      foreach (allp_mem[k, i]) allp_mem[k][i] = 0;
      foreach (comb_pos[k]) comb_pos[k] = 0;
      foreach (allp_pos[k]) allp_pos[k] = 0;
      errors        = 0;
      words_checked = 0;
    endfunction

    // round half up, then floor-divide by 2^15
    function longint q15_round(longint p);
      return (p + 16384) >>> 15;
    endfunction

    function longint clamp(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // zero acts as one, anything past the depth acts as the depth
    function int active_len(int reg_val, int depth);
      if (reg_val == 0) return 1;
      if (reg_val > depth) return depth;
      return reg_val;
    endfunction

    // wrap when at or past the length, so a shrunk length still uses the old slot once
    function int step_pos(int p, int len);
      return (p + 1 >= len) ? 0 : p + 1;
    endfunction

    function longint comb_step(int k, longint x);
      int     p;
      longint w;
      p = comb_pos[k] % COMB_WORDS;
      w = clamp(q15_round(longint'(comb_mem[k][p]) * COMB_GAINS[k]) + x, LINE_W);
      comb_mem[k][p] = int'(w);
      comb_pos[k] = step_pos(p, active_len(int'(comb_len[k]), COMB_WORDS));
      return w;
    endfunction

    function longint allp_step(int k, longint v);
      int     p;
      longint f;
      longint w;
      p = allp_pos[k] % ALLP_WORDS;
      f = longint'(allp_mem[k][p]) - q15_round(v * ALLP_GAIN);
      w = clamp(q15_round(f * ALLP_GAIN) + v, LINE_W);
      allp_mem[k][p] = int'(w);
      allp_pos[k] = step_pos(p, active_len(int'(allp_len[k]), ALLP_WORDS));
      return w;
    endfunction

    function void write_reg(logic [srv_pkg::CFG_ADDR_BITS-1:0] idx,
                            logic [srv_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        srv_pkg::CFG_WET_MIX:      wet_reg     = data[srv_pkg::WET_BITS-1:0];
        srv_pkg::CFG_COMB0_LENGTH: comb_len[0] = data[srv_pkg::COMB_LEN_BITS-1:0];
        srv_pkg::CFG_COMB1_LENGTH: comb_len[1] = data[srv_pkg::COMB_LEN_BITS-1:0];
        srv_pkg::CFG_COMB2_LENGTH: comb_len[2] = data[srv_pkg::COMB_LEN_BITS-1:0];
        srv_pkg::CFG_COMB3_LENGTH: comb_len[3] = data[srv_pkg::COMB_LEN_BITS-1:0];
        srv_pkg::CFG_ALLP0_LENGTH: allp_len[0] = data[srv_pkg::ALLP_LEN_BITS-1:0];
        srv_pkg::CFG_ALLP1_LENGTH: allp_len[1] = data[srv_pkg::ALLP_LEN_BITS-1:0];
        srv_pkg::CFG_ALLP2_LENGTH: allp_len[2] = data[srv_pkg::ALLP_LEN_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Advance the model by one accepted frame and queue the word it owes.
    function void note_frame(logic signed [SMP_BITS-1:0] left, logic signed [SMP_BITS-1:0] right,
                             logic last);
      longint       x;
      longint       sum;
      longint       v;
      longint       wet;
      longint       dry;
      stereo_word_t owed;
      x   = longint'(left);
      sum = 0;
      for (int k = 0; k < srv_pkg::NUM_COMB; k++) sum += comb_step(k, x);
      v = (sum + 2) >>> 2;
      for (int k = 0; k < srv_pkg::NUM_ALLP; k++) v = allp_step(k, v);
      wet = (wet_reg > FULL_WET) ? longint'(FULL_WET) : longint'(wet_reg);
      dry = longint'(FULL_WET) - wet;
      owed.left  = SMP_BITS'(clamp(q15_round(dry * x + wet * v), SMP_BITS));
      owed.right = SMP_BITS'(clamp(q15_round(dry * longint'(right) + wet * v), SMP_BITS));
      owed.last  = last;
      owed_q.push_back(owed);
    endfunction

    function void check_word(logic [2*SMP_BITS-1:0] data, logic last);
      stereo_word_t owed;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: output word %h with nothing expected", $time, data);
        return;
      end
      owed = owed_q.pop_front();
      words_checked++;
      if (data[SMP_BITS-1:0] !== owed.left) begin
        errors++;
        $display("%0t: left_out expected %0d got %0d", $time,
                 $signed(owed.left), $signed(data[SMP_BITS-1:0]));
      end
      if (data[2*SMP_BITS-1:SMP_BITS] !== owed.right) begin
        errors++;
        $display("%0t: right_out expected %0d got %0d", $time,
                 $signed(owed.right), $signed(data[2*SMP_BITS-1:SMP_BITS]));
      end
      if (last !== owed.last) begin
        errors++;
        $display("%0t: frame_last_out expected %0b got %0b", $time, owed.last, last);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              cfg_we;
  logic [srv_pkg::CFG_ADDR_BITS-1:0] cfg_addr;
  logic [srv_pkg::CFG_DATA_BITS-1:0] cfg_data;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [2*SMP_BITS-1:0]             s_tdata;   // left_in, right_in
  logic                              s_tlast;   // frame_last
  logic                              m_tvalid;
  logic                              m_tready;
  logic [2*SMP_BITS-1:0]             m_tdata;   // left_out, right_out
  logic                              m_tlast;   // frame_last_out

  reverb_scoreboard sb = new();
  bit               no_idle = 1'b0;   // set to run a phase with both sides at full rate
  int               settings_done = 0;

  always #5 clk = ~clk;

  schroeder_reverb DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Offer one frame after a random gap and hold it until the block takes it.
  // The caller sits on a rising edge; lower tvalid only when a gap follows, so a
  // back-to-back word keeps tvalid high with a single assignment.
  task automatic send_frame(logic [SMP_BITS-1:0] left, logic [SMP_BITS-1:0] right, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {right, left};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_frame(left, right, last);
  endtask

  // Drop tvalid, wait for every owed word, then let the block finish its last pass.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers back to back; the block is idle when this runs.
  task automatic apply_setting(logic [15:0] wet, logic [15:0] c0, logic [15:0] c1,
                               logic [15:0] c2, logic [15:0] c3, logic [15:0] a0,
                               logic [15:0] a1, logic [15:0] a2);
    logic [srv_pkg::CFG_DATA_BITS-1:0] vals [8];
    vals = '{wet, c0, c1, c2, c3, a0, a1, a2};
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= REG_ORDER[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(REG_ORDER[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  function automatic logic [15:0] pick_comb_len();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd4096;
      2:       return 16'($urandom_range(4097, 8191));   // past the depth
      3:       return 16'($urandom_range(65, 4095));
      default: return 16'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [15:0] pick_allp_len();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd512;
      2:       return 16'($urandom_range(513, 1023));    // past the depth
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [15:0] pick_wet();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'($urandom_range(32769, 65535)); // above unity, clamps
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // Sample source: chunks of full-scale drive of one sign push the delay lines
  // toward saturation, other chunks are uniform or low-level noise.
  function automatic logic [15:0] pick_sample(int style);
    case (style)
      0:       return 16'h7fff - 16'($urandom_range(0, 3));
      1:       return 16'h8000 + 16'($urandom_range(0, 3));
      2:       return 16'($signed($urandom_range(0, 511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_frames(int count);
    int style;
    style = 3;
    for (int n = 0; n < count; n++) begin
      if (n % 24 == 0) style = ($urandom_range(0, 1) == 0) ? 3 : $urandom_range(0, 2);
      send_frame(pick_sample(style), 16'($urandom), 1'($urandom));
    end
  endtask

  // Sink: stall a random number of cycles per word, then take and check it.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_word(m_tdata, m_tlast);
    end
  end

  initial begin
    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: full-scale extremes, sign edges and the frame marker both ways.
    // The block holds s_tready low through its clearing pass, the handshake absorbs that.
    send_frame(16'h7fff, 16'h8000, 1'b0);
    send_frame(16'h8000, 16'h7fff, 1'b1);
    send_frame(16'h0000, 16'h0000, 1'b0);
    send_frame(16'hffff, 16'hffff, 1'b1);
    send_frame(16'h0001, 16'h0001, 1'b0);
    send_frame(16'h5555, 16'haaaa, 1'b0);
    send_frame(16'haaaa, 16'h5555, 1'b1);
    for (int i = 0; i < 6; i++) send_frame(16'h7fff, 16'h7fff, 1'b0);
    for (int i = 0; i < 6; i++) send_frame(16'h8000, 16'h8000, 1'b1);
    random_frames(100);
    drain();

    // Short lines, fully wet, sustained full-scale drive: feedback builds up to
    // line saturation and the mixed outputs clip.
    apply_setting(16'd32768, 16'd1, 16'd2, 16'd3, 16'd5, 16'd1, 16'd2, 16'd3);
    for (int i = 0; i < 40; i++) send_frame(16'h7fff, 16'h7fff, 1'(i));
    for (int i = 0; i < 40; i++) send_frame(16'h8000, 16'h8000, 1'(i));
    random_frames(120);
    drain();

    // Dry only, zero lengths acting as one, lengths at and past the depths.
    // Run both sides at full rate for this phase.
    no_idle = 1'b1;
    apply_setting(16'd0, 16'd0, 16'd8191, 16'd4096, 16'd100, 16'd0, 16'd1023, 16'd512);
    random_frames(200);
    drain();
    no_idle = 1'b0;

    // Wet above unity; lengths shrink below the positions left by the last phase.
    apply_setting(16'd65535, 16'd37, 16'd41, 16'd43, 16'd47, 16'd5, 16'd3, 16'd2);
    random_frames(200);
    drain();

    // Random settings, extremes mixed in.
    for (int p = 0; p < 4; p++) begin
      apply_setting(pick_wet(), pick_comb_len(), pick_comb_len(), pick_comb_len(),
                    pick_comb_len(), pick_allp_len(), pick_allp_len(), pick_allp_len());
      random_frames(RANDOM_FRAMES);
      drain();
    end

    $display("tb: %0d frames checked across reset values and %0d register settings",
             sb.words_checked, settings_done);
    $display("tb: covered saturation, zero and oversized lengths, wet above unity");
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs under a millisecond.
  initial begin
    #8ms;
    $display("tb: errors");
    $finish;
  end

endmodule

@@ files.f @@
src/srv_pkg.sv
src/srv_ram.sv
src/schroeder_reverb.sv
sim/tb.sv
